/* src/ffsa_pkg.sv */
package ffsa_pkg;

  localparam int DEF_NUM_SEGMENTS  = 64;
  localparam int DEF_SEGMENT_CHARS = 256;
  localparam int DEF_NUM_CLIENTS   = 16;

  localparam int OPCODE_W = 2;
  localparam int SIZE_W   = 15;
  localparam int START_W  = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_ALLOC    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE_ALL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

/* src/ffsa_seg_map.sv */
module ffsa_seg_map
  import ffsa_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = DEF_NUM_SEGMENTS,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/first_fit_segment_allocator.sv */
// First-fit allocator of contiguous pool segments. An allocate transfer takes
// the lowest free client slot, turns the size into a segment count (rounded up,
// at least one) and hands out the first run of free segments from segment 0; a
// free transfer releases the run of the client holding the given start; free-all
// clears every segment and slot. Every item gives exactly one result. All work
// goes through one add/compare step per cycle and one segment flag read per
// cycle from a memory with registered read. Allocate runs a slot scan, size
// conversion, segment scan and marking; free runs a slot scan and unmarking;
// free-all makes one clearing write per segment and unused opcodes go straight
// to the result. After reset the input stays not ready while the segment map
// is cleared. The input is ready again once the result sits in the output
// register; a stalled result holds the block for as long as the stall lasts.
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int NUM_SEGMENTS  = DEF_NUM_SEGMENTS,
  parameter int SEGMENT_CHARS = DEF_SEGMENT_CHARS,
  parameter int NUM_CLIENTS   = DEF_NUM_CLIENTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // opcode, size_chars, start_segment
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status, start_out, granted_count
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int SEG_W  = $clog2(NUM_SEGMENTS);
  localparam int CNT_W  = $clog2(NUM_SEGMENTS + 1);
  localparam int SLOT_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int ACC_W  = $clog2((1 << SIZE_W) + SEGMENT_CHARS) + 1;
  localparam int CMP_W  = (SEG_W > START_W) ? SEG_W : START_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SLOT   = 4'd1;
  localparam logic [3:0] S_NEED   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_MARK   = 4'd4;
  localparam logic [3:0] S_FSCAN  = 4'd5;
  localparam logic [3:0] S_UNMARK = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;
  localparam logic [3:0] S_CLEAR  = 4'd8;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_CLIENTS - 1);
  localparam logic [SEG_W-1:0]  LAST_SEG  = SEG_W'(NUM_SEGMENTS - 1);
  localparam logic [CNT_W-1:0]  MAX_NEED  = CNT_W'(NUM_SEGMENTS);
  localparam logic [ACC_W-1:0]  SEG_CHARS = ACC_W'(SEGMENT_CHARS);

  logic [3:0]             state;
  logic                   init_pass;
  logic [NUM_CLIENTS-1:0] slot_valid;
  logic [SEG_W-1:0]       slot_start [NUM_CLIENTS];
  logic [CNT_W-1:0]       slot_count [NUM_CLIENTS];

  logic [SIZE_W-1:0]   req_size;
  logic [START_W-1:0]  req_start;
  logic [SLOT_W-1:0]   slot_idx;
  logic [ACC_W-1:0]    acc;
  logic [CNT_W-1:0]    need;
  logic [SEG_W-1:0]    seg_idx;
  logic [SEG_W-1:0]    run_start;
  logic [CNT_W-1:0]    run_len;
  logic [CNT_W-1:0]    rem;
  logic [STATUS_W-1:0] res_status;
  logic [START_W-1:0]  res_start;
  logic [COUNT_W-1:0]  res_count;

  logic [OPCODE_W-1:0] in_opcode;
  logic [SIZE_W-1:0]   in_size;
  logic [START_W-1:0]  in_start;
  logic                accept;
  logic                load_out;
  logic                rd_used;
  logic                slot_hit;
  logic                fit;
  logic [CNT_W-1:0]    run_len_inc;
  logic                seg_we;
  logic                seg_wdata;
  logic [SEG_W-1:0]    seg_addr;

  assign in_opcode = s_axis_tdata[OPCODE_W-1:0];
  assign in_size   = s_axis_tdata[OPCODE_W+SIZE_W-1:OPCODE_W];
  assign in_start  = s_axis_tdata[OPCODE_W+SIZE_W+START_W-1:OPCODE_W+SIZE_W];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  assign slot_hit    = slot_valid[slot_idx] &&
                       (CMP_W'(slot_start[slot_idx]) == CMP_W'(req_start));
  assign run_len_inc = run_len + 1'b1;
  assign fit         = run_len_inc >= need;

  assign seg_we    = (state == S_MARK) || (state == S_UNMARK) || (state == S_CLEAR);
  assign seg_wdata = (state == S_MARK);
  // read one segment ahead while scanning so the flag arrives with seg_idx
  assign seg_addr  = (state == S_SCAN) ? seg_idx + 1'b1 : seg_idx;

  ffsa_seg_map #(
    .WIDTH (1),
    .DEPTH (NUM_SEGMENTS)
  ) u_seg_map (
    .clk   (clk),
    .we    (seg_we),
    .addr  (seg_addr),
    .wdata (seg_wdata),
    .rdata (rd_used)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      init_pass     <= 1'b1;
      seg_idx       <= '0;
      slot_valid    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {1'b0, res_count, res_start, res_status};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_size   <= in_size;
            req_start  <= in_start;
            slot_idx   <= '0;
            seg_idx    <= '0;
            res_status <= ST_OK;
            res_start  <= '0;
            res_count  <= '0;
            unique case (in_opcode)
              OP_ALLOC: state <= S_SLOT;
              OP_FREE:  state <= S_FSCAN;
              OP_FREE_ALL: begin
                slot_valid <= '0;
                state      <= S_CLEAR;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SLOT: begin
          if (!slot_valid[slot_idx]) begin
            acc   <= SEG_CHARS;
            need  <= CNT_W'(1);
            state <= S_NEED;
          end else if (slot_idx == LAST_SLOT) begin
            res_status <= ST_NO_SLOT;
            state      <= S_DONE;
          end else begin
            slot_idx <= slot_idx + 1'b1;
          end
        end
        S_NEED: begin
          // one segment more per cycle until it covers the size
          if (acc >= ACC_W'(req_size)) begin
            seg_idx   <= '0;
            run_start <= '0;
            run_len   <= '0;
            state     <= S_SCAN;
          end else if (need == MAX_NEED) begin
            res_status <= ST_POOL_FULL;
            state      <= S_DONE;
          end else begin
            need <= need + 1'b1;
            acc  <= acc + SEG_CHARS;
          end
        end
        S_SCAN: begin
          if (!rd_used && fit) begin
            seg_idx <= run_start;
            rem     <= need;
            state   <= S_MARK;
          end else begin
            if (rd_used) begin
              run_len   <= '0;
              run_start <= seg_idx + 1'b1;
            end else begin
              run_len <= run_len_inc;
            end
            if (seg_idx == LAST_SEG) begin
              res_status <= ST_POOL_FULL;
              state      <= S_DONE;
            end else begin
              seg_idx <= seg_idx + 1'b1;
            end
          end
        end
        S_MARK: begin
          if (rem == CNT_W'(1)) begin
            slot_valid[slot_idx] <= 1'b1;
            slot_start[slot_idx] <= run_start;
            slot_count[slot_idx] <= need;
            res_start            <= START_W'(run_start);
            res_count            <= COUNT_W'(need);
            state                <= S_DONE;
          end else begin
            rem     <= rem - 1'b1;
            seg_idx <= seg_idx + 1'b1;
          end
        end
        S_FSCAN: begin
          if (slot_hit) begin
            seg_idx <= slot_start[slot_idx];
            rem     <= slot_count[slot_idx];
            state   <= S_UNMARK;
          end else if (slot_idx == LAST_SLOT) begin
            res_status <= ST_NOT_FOUND;
            res_start  <= req_start;
            state      <= S_DONE;
          end else begin
            slot_idx <= slot_idx + 1'b1;
          end
        end
        S_UNMARK: begin
          if (rem == CNT_W'(1)) begin
            slot_valid[slot_idx] <= 1'b0;
            res_start            <= START_W'(slot_start[slot_idx]);
            res_count            <= COUNT_W'(slot_count[slot_idx]);
            state                <= S_DONE;
          end else begin
            rem     <= rem - 1'b1;
            seg_idx <= seg_idx + 1'b1;
          end
        end
        S_CLEAR: begin
          // the pass after reset returns to idle without a result
          if (seg_idx == LAST_SEG) begin
            init_pass <= 1'b0;
            state     <= init_pass ? S_IDLE : S_DONE;
          end else begin
            seg_idx <= seg_idx + 1'b1;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while waiting");

  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK || state == S_UNMARK) |-> rem != '0)
    else $error("run length ran out while marking");

  a_no_slot_full: assert property (@(posedge clk) disable iff (rst)
    load_out && res_status == ST_NO_SLOT |-> &slot_valid)
    else $error("no-slot result while a slot is free");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    load_out && res_status != ST_OK |-> res_count == '0)
    else $error("error result carries a segment count");

  a_scan_need: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> need != '0 && need <= MAX_NEED)
    else $error("segment count out of range during scan");

endmodule

/* tb/tb.sv */
module tb;
  import ffsa_pkg::*;

  localparam int NUM_SEGS    = DEF_NUM_SEGMENTS;
  localparam int SEG_CHARS   = DEF_SEGMENT_CHARS;
  localparam int NUM_SLOTS   = DEF_NUM_CLIENTS;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int DRAIN_WAIT  = 300;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // status sits in the low bits, as on the result bus
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [START_W-1:0]  seg;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // opcode, size_chars, start_segment
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // status, start_out, granted_count
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  first_fit_segment_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // pool picture kept alongside the block
  bit                 seg_used [NUM_SEGS];
  bit                 slot_busy [NUM_SLOTS];
  logic [START_W-1:0] slot_first [NUM_SLOTS];
  logic [COUNT_W-1:0] slot_len [NUM_SLOTS];

  outcome_t pending_results[$];
  outcome_t want, got;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int requests = 0;
  int n_granted = 0;
  int n_full = 0;
  int n_no_slot = 0;
  int n_missing = 0;
  int cycle_count = 0;

  function automatic outcome_t apply_request(input logic [OPCODE_W-1:0] op,
                                             input logic [SIZE_W-1:0] sz,
                                             input logic [START_W-1:0] seg);
    outcome_t r;
    int slot;
    int need;
    int run_start;
    int run_len;
    bit found;
    r = '0;
    case (op)
      OP_ALLOC: begin
        slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
          if (!slot_busy[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.status = ST_NO_SLOT;
          return r;
        end
        need = (int'(sz) + SEG_CHARS - 1) / SEG_CHARS;
        if (need == 0) need = 1;
        found = 1'b0;
        run_start = 0;
        run_len = 0;
        if (need <= NUM_SEGS) begin
          for (int i = 0; i < NUM_SEGS && !found; i++) begin
            if (seg_used[i]) begin
              run_len = 0;
              run_start = i + 1;
            end else begin
              run_len++;
              if (run_len >= need) found = 1'b1;
            end
          end
        end
        if (!found) begin
          r.status = ST_POOL_FULL;
          return r;
        end
        for (int i = run_start; i < run_start + need; i++) seg_used[i] = 1'b1;
        slot_busy[slot]  = 1'b1;
        slot_first[slot] = START_W'(run_start);
        slot_len[slot]   = COUNT_W'(need);
        r.status = ST_OK;
        r.seg    = START_W'(run_start);
        r.count  = COUNT_W'(need);
      end
      OP_FREE: begin
        r.status = ST_NOT_FOUND;
        r.seg    = seg;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (r.status == ST_NOT_FOUND && slot_busy[i] && slot_first[i] == seg) begin
            for (int k = 0; k < slot_len[i]; k++)
              if (int'(seg) + k < NUM_SEGS) seg_used[int'(seg) + k] = 1'b0;
            slot_busy[i] = 1'b0;
            r.status = ST_OK;
            r.count  = slot_len[i];
          end
        end
      end
      OP_FREE_ALL: begin
        for (int i = 0; i < NUM_SEGS; i++) seg_used[i] = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) slot_busy[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SIZE_W-1:0] sz,
                           input logic [START_W-1:0] seg);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, seg, sz, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests++;
    pending_results.push_back(apply_request(op, sz, seg));
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = outcome_t'(m_axis_tdata[COUNT_W+START_W+STATUS_W-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.seg != want.seg) begin
          $display("%0t: start_out expected %0d actual %0d", $time, want.seg, got.seg);
          errors++;
        end
        if (got.count != want.count) begin
          $display("%0t: granted_count expected %0d actual %0d", $time, want.count,
                   got.count);
          errors++;
        end
        case (want.status)
          ST_OK:        if (want.count != 0) n_granted++;
          ST_NO_SLOT:   n_no_slot++;
          ST_POOL_FULL: n_full++;
          default:      n_missing++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // rounding of sizes, free paths and the ignored opcode
  task automatic test_sizes_and_frees();
    send_item(OP_ALLOC, 15'd0, 6'd63);
    send_item(OP_ALLOC, 15'd256, 6'd0);
    send_item(OP_ALLOC, 15'd257, 6'd21);
    send_item(OP_FREE, 15'h7fff, 6'd1);
    send_item(OP_UNUSED, 15'h7fff, 6'h3f);
    send_item(OP_FREE, 15'd0, 6'd63);
    send_item(OP_ALLOC, 15'd16385, 6'd0);
    send_item(OP_ALLOC, 15'd1, 6'd0);
    send_item(OP_FREE_ALL, 15'h2aaa, 6'h2a);
  endtask

  // whole pool in one run, then nothing fits
  task automatic test_full_pool();
    send_item(OP_ALLOC, 15'd16384, 6'd0);
    send_item(OP_ALLOC, 15'd0, 6'd0);
    send_item(OP_FREE, 15'h5555, 6'd0);
  endtask

  // fill every client slot; the slot check wins over the size check
  task automatic test_slot_exhaustion();
    for (int i = 0; i < NUM_SLOTS; i++) send_item(OP_ALLOC, 15'd1, 6'd0);
    send_item(OP_ALLOC, 15'd16384, 6'd0);
    send_item(OP_FREE_ALL, 15'd0, 6'd0);
  endtask

  task automatic test_random(input int n, input int s_idle, input int r_idle);
    int pick;
    logic [START_W-1:0] live[$];
    logic [SIZE_W-1:0] sz;
    logic [START_W-1:0] seg;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      sz = SIZE_W'($urandom);
      seg = START_W'($urandom);
      if (pick < 48) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5, 6: sz = SIZE_W'($urandom_range(1024));
          7, 8:                sz = SIZE_W'($urandom_range(4096));
          default:             sz = SIZE_W'($urandom_range(16384));
        endcase
        send_item(OP_ALLOC, sz, seg);
      end else if (pick < 88) begin
        // release a run that is actually held
        live.delete();
        for (int k = 0; k < NUM_SLOTS; k++)
          if (slot_busy[k]) live.push_back(slot_first[k]);
        if (live.size() != 0) seg = live[$urandom_range(live.size() - 1)];
        send_item(OP_FREE, sz, seg);
      end else if (pick < 95) begin
        send_item(OP_FREE, sz, seg);
      end else if (pick < 98) begin
        send_item(OP_FREE_ALL, sz, seg);
      end else begin
        send_item(OP_UNUSED, sz, seg);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sizes_and_frees();
    test_full_pool();
    test_slot_exhaustion();
    test_random(330, 30, 72);
    test_random(330, 72, 30);
    test_random(340, 0, 0);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d requests: %0d runs granted or released, %0d pool full,",
             requests, n_granted, n_full);
    $display("%0d with no client slot, %0d frees of unknown runs", n_no_slot, n_missing);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
